FILE: hw/rtl/drlt_pkg.sv
package drlt_pkg;

  localparam int VAL_W     = 16;
  localparam int FRAC_BITS = 12;
  localparam int ACC_W     = 48;
  localparam int TIDX_W    = 10;
  localparam int CNT_O_W   = 9;

  localparam int DEF_MAX_INPUTS  = 64;
  localparam int DEF_MAX_OUTPUTS = 16;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_BIAS   = 2'd1;
  localparam logic [1:0] REQ_ACT    = 2'd2;
  localparam logic [1:0] REQ_ERROR  = 2'd3;

  localparam logic [1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] CFG_RATE_SHIFT   = 2'd2;

  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_BWD = 1'b1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [3:0]        out_index;
    logic [5:0]        in_index;
    logic signed [15:0] value;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [5:0]        result_index;
    logic signed [15:0] result_value;
    logic              result_last;
  } out_item_t;

  typedef struct packed {
    logic                    vld;
    logic                    tail;
    logic [TIDX_W-1:0]       idx;
    logic signed [VAL_W-1:0] af;
    logic signed [ACC_W-1:0] psum;
  } tok_t;

  typedef struct packed {
    logic                    en;
    logic                    fwd;
    logic                    start;
    logic                    cap;
    logic                    shift;
    logic                    wwe;
    logic                    bwe;
    logic                    dwe;
    logic [3:0]              oi;
    logic [TIDX_W-1:0]       wi;
    logic signed [VAL_W-1:0] value;
    logic [4:0]              rs;
    logic [CNT_O_W-1:0]      no;
  } cell_ctrl_t;

  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                   input logic [5:0] s);
    logic signed [63:0] t;
    if (s == 6'd0) begin
      rnd_shift = x;
    end else begin
      t = x + (64'sd1 <<< (s - 6'd1));
      rnd_shift = t >>> s;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] x);
    if (x > 64'sd32767) sat_val = 16'sh7fff;
    else if (x < -64'sd32768) sat_val = 16'sh8000;
    else sat_val = x[VAL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/drlt_cell.sv
module drlt_cell import drlt_pkg::*; #(
  parameter int MAX_INPUTS = DEF_MAX_INPUTS,
  parameter int ID         = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctrl_t              ctrl,
  input  tok_t                    tok_in,
  output tok_t                    tok_out,
  input  logic signed [VAL_W-1:0] sh_in,
  output logic signed [VAL_W-1:0] sh_out
);

  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  logic signed [VAL_W-1:0] row [MAX_INPUTS];
  logic signed [VAL_W-1:0] wq_r, w2_r;
  logic signed [VAL_W-1:0] bias_r, act_r, delta_r, sh_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0]      pa_r, pb_r;
  tok_t                    t1_r, t2_r, t3_r;
  tok_t                    t3_nxt;

  logic                    active, match, upd;
  logic signed [VAL_W-1:0] w_nxt, bias_nxt, r_val;
  logic signed [63:0]      racc;

  assign active = (32'(ctrl.no) > ID);
  assign match  = (32'(ctrl.oi) == ID);
  assign upd    = ctrl.en && !ctrl.fwd && t2_r.vld && active;

  always_comb begin
    w_nxt    = sat_val(64'(w2_r) + rnd_shift(64'(pb_r), 6'(FRAC_BITS) + 6'(ctrl.rs)));
    bias_nxt = sat_val(64'(bias_r) + rnd_shift(64'(delta_r), 6'(ctrl.rs)));
    racc     = rnd_shift(64'(acc_r), 6'(FRAC_BITS));
    if (racc < 0) r_val = '0;
    else r_val = sat_val(racc);
    t3_nxt = t2_r;
    if (!ctrl.fwd && active) t3_nxt.psum = t2_r.psum + ACC_W'(pa_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.wwe && match) begin
      row[ctrl.wi[IW-1:0]] <= ctrl.value;
    end else if (upd) begin
      row[t2_r.idx[IW-1:0]] <= w_nxt;
    end
    if (ctrl.en) begin
      wq_r <= row[tok_in.idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= '0;
      delta_r <= '0;
      t1_r.vld <= 1'b0;
      t2_r.vld <= 1'b0;
      t3_r.vld <= 1'b0;
    end else begin
      if (ctrl.bwe && match) begin
        bias_r <= ctrl.value;
      end else if (ctrl.start && !ctrl.fwd && active) begin
        bias_r <= bias_nxt;
      end
      if (ctrl.dwe && match) begin
        delta_r <= (act_r != '0) ? ctrl.value : '0;
      end
      if (ctrl.start && ctrl.fwd) begin
        acc_r <= ACC_W'(bias_r) <<< FRAC_BITS;
      end else if (ctrl.en && ctrl.fwd && t2_r.vld) begin
        acc_r <= acc_r + ACC_W'(pa_r);
      end
      if (ctrl.cap) begin
        sh_r <= r_val;
        if (active) act_r <= r_val;
      end else if (ctrl.shift) begin
        sh_r <= sh_in;
      end
      if (ctrl.en) begin
        t1_r <= tok_in;
        t2_r <= t1_r;
        w2_r <= wq_r;
        pa_r <= wq_r * (ctrl.fwd ? t1_r.af : delta_r);
        pb_r <= delta_r * t1_r.af;
        t3_r <= t3_nxt;
      end
    end
  end

  assign tok_out = t3_r;
  assign sh_out  = sh_r;

endmodule

FILE: hw/rtl/dense_relu_layer_train_core.sv
// Channel  Ports                          Moves
// input    in_valid, in_stall, in_data     one request transaction (write, load, last)
// output   out_valid, out_stall, out_data  one activation or back-propagated error
// config   cfg_we, cfg_addr, cfg_wdata     register write, no wait
// Load and write transactions are accepted whenever in_stall is low.
// In a forward pass activations stream down the row of neuron cells, one weight
// MAC per cell per cycle while the output is not stalled.
// In a backward pass partial sums ride the chain. Input is stalled during a pass;
// output stall freezes the whole chain. Reset clears control state, activations
// and deltas; weights and biases need writes.
module dense_relu_layer_train_core import drlt_pkg::*; #(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [6:0] cfg_wdata
);

  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int CW = $clog2(MAX_INPUTS + 1);
  localparam int OW = $clog2(MAX_OUTPUTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]  state_r;
  logic [6:0]  icnt_r;
  logic [4:0]  ocnt_r;
  logic [4:0]  rs_r;
  logic        fwd_r, start_r;
  logic [CW-1:0] cnt_r, ni;
  logic [OW-1:0] dcnt_r, no;
  logic signed [VAL_W-1:0] amem [MAX_INPUTS];
  logic signed [VAL_W-1:0] aq_r;
  logic        tv_r, ttail_r;
  logic [CW-1:0] tidx_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic        en, acc_in, tail_out, res_out;
  cell_ctrl_t  ctrl;
  tok_t        chain [MAX_OUTPUTS+1];
  logic signed [VAL_W-1:0] shc [MAX_OUTPUTS+1];

  always_comb begin
    if (icnt_r == '0) ni = CW'(1);
    else if (32'(icnt_r) > MAX_INPUTS) ni = CW'(MAX_INPUTS);
    else ni = CW'(icnt_r);
    if (ocnt_r == '0) no = OW'(1);
    else if (32'(ocnt_r) > MAX_OUTPUTS) no = OW'(MAX_OUTPUTS);
    else no = OW'(ocnt_r);
  end

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign acc_in   = in_valid && !in_stall;
  assign res_out  = en && (state_r == ST_RUN) && chain[MAX_OUTPUTS].vld;
  assign tail_out = res_out && chain[MAX_OUTPUTS].tail;

  always_comb begin
    ctrl.en    = en;
    ctrl.fwd   = fwd_r;
    ctrl.start = start_r;
    ctrl.cap   = tail_out && fwd_r;
    ctrl.shift = en && (state_r == ST_DRAIN);
    ctrl.wwe   = acc_in && (in_data.req_type == REQ_WEIGHT)
                 && (32'(in_data.in_index) < MAX_INPUTS);
    ctrl.bwe   = acc_in && (in_data.req_type == REQ_BIAS);
    ctrl.dwe   = acc_in && (in_data.req_type == REQ_ERROR);
    ctrl.oi    = in_data.out_index;
    ctrl.wi    = TIDX_W'(in_data.in_index);
    ctrl.value = in_data.value;
    ctrl.rs    = rs_r;
    ctrl.no    = CNT_O_W'(no);
  end

  always_comb begin
    chain[0].vld  = tv_r;
    chain[0].tail = ttail_r;
    chain[0].idx  = TIDX_W'(tidx_r);
    chain[0].af   = aq_r;
    chain[0].psum = '0;
  end
  assign shc[MAX_OUTPUTS] = '0;

  for (genvar g = 0; g < MAX_OUTPUTS; g++) begin : g_cell
    drlt_cell #(.MAX_INPUTS(MAX_INPUTS), .ID(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1]),
      .sh_in   (shc[g+1]),
      .sh_out  (shc[g])
    );
  end

  always_ff @(posedge clk) begin
    if (acc_in && (in_data.req_type == REQ_ACT) && (32'(in_data.in_index) < MAX_INPUTS)) begin
      amem[in_data.in_index[IW-1:0]] <= in_data.value;
    end
    if (en) begin
      aq_r <= amem[cnt_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      icnt_r      <= 7'd64;
      ocnt_r      <= 5'd16;
      rs_r        <= 5'd20;
      fwd_r       <= 1'b0;
      start_r     <= 1'b0;
      cnt_r       <= '0;
      dcnt_r      <= '0;
      tv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_INPUT_COUNT:  icnt_r <= cfg_wdata;
          CFG_OUTPUT_COUNT: ocnt_r <= cfg_wdata[4:0];
          CFG_RATE_SHIFT:   rs_r   <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      start_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (acc_in && in_data.last &&
              ((in_data.req_type == REQ_ACT) || (in_data.req_type == REQ_ERROR))) begin
            fwd_r   <= (in_data.req_type == REQ_ACT);
            start_r <= 1'b1;
            cnt_r   <= '0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (en) begin
            tv_r    <= (cnt_r < ni);
            ttail_r <= (cnt_r == ni - CW'(1));
            tidx_r  <= cnt_r;
            if (cnt_r < ni) cnt_r <= cnt_r + CW'(1);
          end
          if (tail_out) begin
            dcnt_r  <= '0;
            state_r <= fwd_r ? ST_DRAIN : ST_IDLE;
          end
        end
        ST_DRAIN: begin
          if (en) begin
            dcnt_r <= dcnt_r + OW'(1);
            if (dcnt_r == no - OW'(1)) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (en) begin
        if (state_r == ST_DRAIN) begin
          out_valid_r         <= 1'b1;
          out_r.result_kind   <= KIND_FWD;
          out_r.result_index  <= 6'(dcnt_r);
          out_r.result_value  <= shc[0];
          out_r.result_last   <= (dcnt_r == no - OW'(1));
        end else if (res_out && !fwd_r) begin
          out_valid_r         <= 1'b1;
          out_r.result_kind   <= KIND_BWD;
          out_r.result_index  <= chain[MAX_OUTPUTS].idx[5:0];
          out_r.result_value  <= sat_val(rnd_shift(64'(chain[MAX_OUTPUTS].psum),
                                                   6'(FRAC_BITS)));
          out_r.result_last   <= chain[MAX_OUTPUTS].tail;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
